// ===== design/assert_macros.svh =====
// assertion helper macros for the rank engine
// no dependencies; the including file supplies clock, reset and expressions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// a holds in the same cycle as b
`define OMRE_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("omre implication check failed");
// a holds, then b in the next cycle
`define OMRE_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("omre next-cycle check failed");
`else
`define OMRE_ASSERT_IMPL(label, clk, rst_n, a, b)
`define OMRE_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== design/omre_pkg.sv =====
// shared types and constants for the ordered multiset rank engine
// no dependencies
package omre_pkg;

  localparam int unsigned MAX_DISTINCT = 1024;
  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_DISTINCT);
  localparam int unsigned CNT_W        = $clog2(MAX_DISTINCT + 1);
  localparam int unsigned TOTAL_W      = 26;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned ST_W         = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_MEMBER = 3'd2;
  localparam logic [OP_W-1:0] OP_MAX    = 3'd3;
  localparam logic [OP_W-1:0] OP_MIN    = 3'd4;
  localparam logic [OP_W-1:0] OP_KTH    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  localparam logic [COUNT_BITS-1:0] MULT_LIMIT  = '1;
  localparam logic [TOTAL_W-1:0]    TOTAL_LIMIT = '1;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] mult;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_CHK_W, S_MV_RD, S_MV_WR, S_PUT,
    S_EXT_W, S_KTH_RD, S_KTH_W, S_DONE
  } state_e;

endpackage

// ===== design/omre_store.sv =====
// sorted entry store: one write port, one read port, registered read data
// depends on omre_pkg
module omre_store (
  input  logic                     clk_i,
  input  omre_pkg::wr_req_t        wr_i,
  input  logic [omre_pkg::IDX_W-1:0] raddr_i,
  output omre_pkg::entry_t         rdata_o
);
  import omre_pkg::*;

  entry_t mem [MAX_DISTINCT];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ordered_multiset_rank_engine.sv =====
// top level of the ordered multiset rank engine: control sequencer and result register
// depends on omre_pkg, omre_store and assert_macros.svh
//
// Ordered multiset of signed 32-bit keys, each distinct key stored once with its
// copy count in a 1024-entry synchronous memory kept in ascending signed order.
// One request is taken at a time; every request gives exactly one result beat.
// Work per request, paced by the registered read data of the store:
//   insert, delete, member: binary search and check, plus a read and a write per
//     entry moved when a new key opens a slot or the last copy of a key closes one
//     (up to n entries)
//   maximum, minimum: a single read of the last or first entry
//   k-th smallest: a read per distinct key scanned from the low end
// where n is the number of distinct keys. No clearing pass is needed after reset:
// only entries below the distinct count are ever used.
// The result register lets the next request be taken while a result waits.
`include "assert_macros.svh"

module ordered_multiset_rank_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [omre_pkg::OP_W-1:0]            opcode_i,
  input  logic signed [omre_pkg::KEY_W-1:0]    key_i,
  input  logic [omre_pkg::TOTAL_W-1:0]         rank_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [omre_pkg::ST_W-1:0]            status_o,
  output logic signed [omre_pkg::KEY_W-1:0]    value_o
);
  import omre_pkg::*;

  state_e state_q, state_d;

  // request registers
  logic [OP_W-1:0]    op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [TOTAL_W-1:0] left_q, left_d;   // rank, then remaining rank during scan

  // search bounds and move pointer
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0] mid_q, mid_d, j_q, j_d;

  // set bookkeeping
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  // pending result and output register
  logic [ST_W-1:0]  res_st_q, res_st_d;
  logic [KEY_W-1:0] res_val_q, res_val_d;
  logic             out_valid_q, out_valid_d;
  logic [ST_W-1:0]  out_st_q, out_st_d;
  logic [KEY_W-1:0] out_val_q, out_val_d;

  wr_req_t          wr;
  logic [IDX_W-1:0] raddr;
  entry_t           rdata;

  omre_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic             in_acc;
  logic [CNT_W-1:0] mid_full;
  logic             key_below;   // stored key orders below the request key
  logic             hit;

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign mid_full  = lo_q + ((hi_q - lo_q) >> 1);
  // flip the sign bit so an unsigned compare follows signed order
  assign key_below = {~rdata.key[KEY_W-1], rdata.key[KEY_W-2:0]} <
                     {~key_q[KEY_W-1], key_q[KEY_W-2:0]};
  assign hit       = (lo_q < count_q) && (rdata.key == key_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    left_d      = left_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    j_d         = j_q;
    count_d     = count_q;
    total_d     = total_q;
    res_st_d    = res_st_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_val_d   = out_val_q;
    wr          = '0;
    raddr       = '0;

    // result beat leaves the output register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d      = opcode_i;
          key_d     = key_i;
          left_d    = rank_i;
          lo_d      = '0;
          hi_d      = count_q;
          j_d       = '0;
          res_val_d = '0;
          res_st_d  = ST_MISS;
          case (opcode_i)
            OP_INSERT, OP_DELETE, OP_MEMBER: begin
              state_d = S_SRCH;
            end
            OP_MAX, OP_MIN: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                raddr   = (opcode_i == OP_MAX) ? IDX_W'(count_q - 1'b1) : '0;
                state_d = S_EXT_W;
              end
            end
            OP_KTH: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_DONE;
              end else if (rank_i == '0 || rank_i > total_q) begin
                state_d = S_DONE;
              end else begin
                state_d = S_KTH_RD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // binary search for the first slot not below the key
      S_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_full[IDX_W-1:0];
          raddr   = mid_full[IDX_W-1:0];
          state_d = S_SRCH_W;
        end else begin
          raddr   = lo_q[IDX_W-1:0];
          state_d = S_CHK_W;
        end
      end

      S_SRCH_W: begin
        if (key_below) begin
          lo_d = CNT_W'(mid_q) + 1'b1;
        end else begin
          hi_d = CNT_W'(mid_q);
        end
        state_d = S_SRCH;
      end

      S_CHK_W: begin
        state_d = S_DONE;
        case (op_q)
          OP_MEMBER: begin
            res_st_d = hit ? ST_OK : ST_MISS;
          end
          OP_INSERT: begin
            if (total_q >= TOTAL_LIMIT) begin
              res_st_d = ST_FULL;
            end else if (hit) begin
              if (rdata.mult >= MULT_LIMIT) begin
                res_st_d = ST_FULL;
              end else begin
                wr.we        = 1'b1;
                wr.addr      = lo_q[IDX_W-1:0];
                wr.data.key  = rdata.key;
                wr.data.mult = rdata.mult + 1'b1;
                total_d      = total_q + 1'b1;
                res_st_d     = ST_OK;
              end
            end else if (count_q >= CNT_W'(MAX_DISTINCT)) begin
              res_st_d = ST_FULL;
            end else begin
              if (lo_q == count_q) begin
                state_d = S_PUT;
              end else begin
                j_d     = IDX_W'(count_q - 1'b1);
                state_d = S_MV_RD;
              end
            end
          end
          OP_DELETE: begin
            if (!hit) begin
              res_st_d = ST_MISS;
            end else begin
              res_st_d = ST_OK;
              if (rdata.mult > COUNT_BITS'(1)) begin
                wr.we        = 1'b1;
                wr.addr      = lo_q[IDX_W-1:0];
                wr.data.key  = rdata.key;
                wr.data.mult = rdata.mult - 1'b1;
                total_d      = total_q - 1'b1;
              end else if (lo_q == count_q - 1'b1) begin
                count_d = count_q - 1'b1;
                total_d = total_q - 1'b1;
              end else begin
                j_d     = IDX_W'(lo_q + 1'b1);
                state_d = S_MV_RD;
              end
            end
          end
          default: begin
            res_st_d = ST_MISS;
          end
        endcase
      end

      // shift entries up (insert) or down (delete) by one slot, reading then writing each entry
      S_MV_RD: begin
        raddr   = j_q;
        state_d = S_MV_WR;
      end

      S_MV_WR: begin
        wr.we   = 1'b1;
        wr.data = rdata;
        if (op_q == OP_INSERT) begin
          wr.addr = j_q + 1'b1;
          if (CNT_W'(j_q) == lo_q) begin
            state_d = S_PUT;
          end else begin
            j_d     = j_q - 1'b1;
            state_d = S_MV_RD;
          end
        end else begin
          wr.addr = j_q - 1'b1;
          if (CNT_W'(j_q) == count_q - 1'b1) begin
            // count and total drop together once the gap is closed
            count_d = count_q - 1'b1;
            total_d = total_q - 1'b1;
            state_d = S_DONE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_MV_RD;
          end
        end
      end

      S_PUT: begin
        wr.we        = 1'b1;
        wr.addr      = lo_q[IDX_W-1:0];
        wr.data.key  = key_q;
        wr.data.mult = COUNT_BITS'(1);
        count_d      = count_q + 1'b1;
        total_d      = total_q + 1'b1;
        res_st_d     = ST_OK;
        state_d      = S_DONE;
      end

      S_EXT_W: begin
        res_st_d  = ST_OK;
        res_val_d = rdata.key;
        state_d   = S_DONE;
      end

      // walk from the smallest key, using up the rank by each copy count
      S_KTH_RD: begin
        raddr   = j_q;
        state_d = S_KTH_W;
      end

      S_KTH_W: begin
        if (left_q > TOTAL_W'(rdata.mult)) begin
          left_d  = left_q - TOTAL_W'(rdata.mult);
          j_d     = j_q + 1'b1;
          state_d = S_KTH_RD;
        end else begin
          res_st_d  = ST_OK;
          res_val_d = rdata.key;
          state_d   = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_val_d   = res_val_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    left_q    <= left_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    j_q       <= j_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
    out_st_q  <= out_st_d;
    out_val_q <= out_val_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign value_o     = out_val_q;

  // every stored key holds at least one copy
  `OMRE_ASSERT_IMPL(a_total_covers_keys, clk_i, rst_ni, 1'b1, TOTAL_W'(count_q) <= total_q)
  `OMRE_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_DISTINCT))
  `OMRE_ASSERT_IMPL(a_empty_total, clk_i, rst_ni, count_q == '0, total_q == '0)
  // the store's size moves by at most one per cycle
  `OMRE_ASSERT_NEXT(a_count_step, clk_i, rst_ni, 1'b1, count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1)

endmodule
